/* hdl/greedy_change_maker_core_assert.svh */
// Assertion macros for the greedy change maker core.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef GREEDY_CHANGE_MAKER_CORE_ASSERT_SVH
`define GREEDY_CHANGE_MAKER_CORE_ASSERT_SVH

// Same-cycle implication.
`define GCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gcm assertion failed");

// Next-cycle implication.
`define GCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gcm assertion failed");

`endif

/* hdl/gcm_pkg.sv */
// Package for the greedy change maker: widths, denomination and reciprocal
// tables, and the control/result structs. No dependencies.
`timescale 1ns / 1ps

package gcm_pkg;

  localparam int AmountWidth = 24;
  localparam int DenomWidth  = 16;
  localparam int CountWidth  = 24;
  localparam int IdxWidth    = 4;
  localparam int NumDenoms   = 15;
  localparam int CoinStart   = 7;

  // Reciprocal divide for the first denomination of each set.
  localparam int RecipWidth  = 25;
  localparam int ProdWidth   = AmountWidth + RecipWidth;
  localparam int ShiftNotes  = 40;
  localparam int ShiftCoins  = 32;
  localparam int QuotWidth   = ProdWidth - ShiftCoins;
  localparam int MulWidth    = QuotWidth + DenomWidth;

  localparam logic [RecipWidth-1:0] RecipNotes = 25'd21990233;  // 2^40 / 50000, rounded up
  localparam logic [RecipWidth-1:0] RecipCoins = 25'd21474837;  // 2^32 / 200, rounded up

  typedef struct packed {
    logic load;
    logic first;
  } cmd_t;

  typedef struct packed {
    logic [CountWidth-1:0]  cnt;
    logic [AmountWidth-1:0] rem;
  } res_t;

  function automatic logic [DenomWidth-1:0] denom_f(input logic [IdxWidth-1:0] idx);
    logic [DenomWidth-1:0] d;
    case (idx)
      4'd0:    d = 16'd50000;
      4'd1:    d = 16'd20000;
      4'd2:    d = 16'd10000;
      4'd3:    d = 16'd5000;
      4'd4:    d = 16'd2000;
      4'd5:    d = 16'd1000;
      4'd6:    d = 16'd500;
      4'd7:    d = 16'd200;
      4'd8:    d = 16'd100;
      4'd9:    d = 16'd50;
      4'd10:   d = 16'd20;
      4'd11:   d = 16'd10;
      4'd12:   d = 16'd5;
      4'd13:   d = 16'd2;
      4'd14:   d = 16'd1;
      default: d = 16'd1;
    endcase
    return d;
  endfunction

endpackage

/* hdl/gcm_if.sv */
// Stream interfaces for the greedy change maker: input word and result word.
// Depends on gcm_pkg for field widths.
`timescale 1ns / 1ps

interface gcm_in_if;
  logic                               valid;
  logic                               ready;
  logic [gcm_pkg::AmountWidth-1:0]    amount_cents;
  logic                               use_notes;

  modport source (output valid, output amount_cents, output use_notes, input ready);
  modport sink   (input valid, input amount_cents, input use_notes, output ready);
endinterface

interface gcm_out_if;
  logic                               valid;
  logic                               ready;
  logic [gcm_pkg::DenomWidth-1:0]     denomination_cents;
  logic [gcm_pkg::CountWidth-1:0]     piece_count;
  logic                               is_last;

  modport source (output valid, output denomination_cents, output piece_count,
                  output is_last, input ready);
  modport sink   (input valid, input denomination_cents, input piece_count,
                  input is_last, output ready);
endinterface

/* hdl/gcm_div_unit.sv */
// Shared divide unit: reciprocal multiply for the first denomination,
// compare-subtract for the rest. Depends on gcm_pkg.
`timescale 1ns / 1ps

module gcm_div_unit (
  input  logic                            clk_i,
  input  gcm_pkg::cmd_t                   cmd_i,
  input  logic [gcm_pkg::AmountWidth-1:0] load_amt_i,
  input  logic                            load_notes_i,
  input  logic [gcm_pkg::AmountWidth-1:0] dividend_i,
  input  logic [gcm_pkg::IdxWidth-1:0]    idx_i,
  input  logic                            notes_i,
  output gcm_pkg::res_t                   res_o
);

  logic [gcm_pkg::ProdWidth-1:0]   prod_q;
  logic [gcm_pkg::RecipWidth-1:0]  recip;
  logic [gcm_pkg::QuotWidth-1:0]   quot;
  logic [gcm_pkg::MulWidth-1:0]    qd;
  logic [gcm_pkg::DenomWidth-1:0]  d;
  logic [gcm_pkg::AmountWidth-1:0] d1;
  logic [gcm_pkg::AmountWidth-1:0] d2;
  logic                            ge1;
  logic                            ge2;

  assign recip = load_notes_i ? gcm_pkg::RecipNotes : gcm_pkg::RecipCoins;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prod_q <= gcm_pkg::ProdWidth'(load_amt_i) * gcm_pkg::ProdWidth'(recip);
    end
  end

  always_comb begin
    d    = gcm_pkg::denom_f(idx_i);
    quot = notes_i ? gcm_pkg::QuotWidth'(prod_q[gcm_pkg::ProdWidth-1:gcm_pkg::ShiftNotes])
                   : prod_q[gcm_pkg::ProdWidth-1:gcm_pkg::ShiftCoins];
    qd   = gcm_pkg::MulWidth'(quot) * gcm_pkg::MulWidth'(d);
    d1   = gcm_pkg::AmountWidth'(d);
    d2   = d1 << 1;
    ge2  = dividend_i >= d2;
    ge1  = dividend_i >= d1;
    if (cmd_i.first) begin
      res_o.cnt = gcm_pkg::CountWidth'(quot);
      res_o.rem = dividend_i - qd[gcm_pkg::AmountWidth-1:0];
    end else if (ge2) begin
      res_o.cnt = gcm_pkg::CountWidth'(2);
      res_o.rem = dividend_i - d2;
    end else if (ge1) begin
      res_o.cnt = gcm_pkg::CountWidth'(1);
      res_o.rem = dividend_i - d1;
    end else begin
      res_o.cnt = '0;
      res_o.rem = dividend_i;
    end
  end

endmodule

/* hdl/greedy_change_maker_core.sv */
// Greedy change maker top level: sequencer, shared divide unit, output register.
// Depends on gcm_pkg, gcm_if, gcm_div_unit and the assertion macro header.
//
//   port    dir   word fields
//   in_i    sink  amount_cents[23:0], use_notes
//   out_o   src   denomination_cents[15:0], piece_count[23:0], is_last
//
// Accepting an amount starts the reciprocal multiply; the first denomination is then
// resolved in StFin and each remaining denomination in turn in StStep, until the
// remainder reaches zero or the last denomination is done.
// A zero amount returns to idle at once. The sequencer holds while a used
// denomination waits on a full output register. Reset clears all control state.
`timescale 1ns / 1ps
`include "greedy_change_maker_core_assert.svh"

module greedy_change_maker_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcm_in_if.sink    in_i,
  gcm_out_if.source out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StFin  = 2'd1;
  localparam logic [1:0] StStep = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [gcm_pkg::AmountWidth-1:0] rem_q, rem_d;
  logic [gcm_pkg::IdxWidth-1:0]    idx_q, idx_d;
  logic                            notes_q, notes_d;

  logic                            out_valid_q, out_valid_d;
  logic [gcm_pkg::DenomWidth-1:0]  out_denom_q, out_denom_d;
  logic [gcm_pkg::CountWidth-1:0]  out_cnt_q, out_cnt_d;
  logic                            out_last_q, out_last_d;

  gcm_pkg::cmd_t cmd;
  gcm_pkg::res_t res;
  logic          accept;
  logic          working;
  logic          emit;
  logic          out_free;
  logic          advance;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign working    = (state_q == StFin) || (state_q == StStep);
  assign emit       = working && (res.cnt != '0);
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = working && (!emit || out_free);

  assign cmd = '{load: accept, first: (state_q == StFin)};

  gcm_div_unit u_div (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .load_amt_i   (in_i.amount_cents),
    .load_notes_i (in_i.use_notes),
    .dividend_i   (rem_q),
    .idx_i        (idx_q),
    .notes_i      (notes_q),
    .res_o        (res)
  );

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    notes_d     = notes_q;
    out_valid_d = out_valid_q;
    out_denom_d = out_denom_q;
    out_cnt_d   = out_cnt_q;
    out_last_d  = out_last_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          notes_d = in_i.use_notes;
          rem_d   = in_i.amount_cents;
          idx_d   = in_i.use_notes ? '0 : gcm_pkg::IdxWidth'(gcm_pkg::CoinStart);
          state_d = (in_i.amount_cents != '0) ? StFin : StIdle;
        end
      end
      StFin, StStep: begin
        if (advance) begin
          if (emit) begin
            out_valid_d = 1'b1;
            out_denom_d = gcm_pkg::denom_f(idx_q);
            out_cnt_d   = res.cnt;
            out_last_d  = (res.rem == '0);
          end
          rem_d   = res.rem;
          idx_d   = idx_q + 1'b1;
          state_d = ((res.rem == '0) ||
                     (idx_q == gcm_pkg::IdxWidth'(gcm_pkg::NumDenoms - 1))) ? StIdle : StStep;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      idx_q       <= '0;
      notes_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      notes_q     <= notes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_denom_q <= out_denom_d;
    out_cnt_q   <= out_cnt_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.denomination_cents = out_denom_q;
  assign out_o.piece_count        = out_cnt_q;
  assign out_o.is_last            = out_last_q;

  `GCM_ASSERT_NOW(a_busy_rem_nonzero, state_q != StIdle, rem_q != '0)
  `GCM_ASSERT_NEXT(a_start_fin, accept && (in_i.amount_cents != '0), state_q == StFin)
  `GCM_ASSERT_NEXT(a_stall_hold, working && emit && !out_free,
                   $stable(rem_q) && $stable(idx_q) && $stable(state_q))
  `GCM_ASSERT_NEXT(a_last_idle, advance && emit && (res.rem == '0),
                   (state_q == StIdle) && out_valid_q && out_last_q)

endmodule

/* tb/gcm_change_checker.sv */
// Scoreboard for the greedy change maker: watches the amount and change channels,
// predicts the change words for each accepted amount and compares them in order.
// Depends on gcm_pkg and the gcm_in_if / gcm_out_if interfaces.
`timescale 1ns / 1ps

module gcm_change_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gcm_in_if    in_mon_i,
  gcm_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   amounts_o,
  output int   words_o
);

  typedef struct packed {
    logic [gcm_pkg::DenomWidth-1:0] denom;
    logic [gcm_pkg::CountWidth-1:0] pieces;
    logic                           last;
  } change_word_t;

  localparam int unsigned EuroDenoms [15] = '{
    50000, 20000, 10000, 5000, 2000, 1000, 500, 200, 100, 50, 20, 10, 5, 2, 1
  };
  localparam int FirstCoin   = 7;
  localparam int ReportLimit = 10;

  change_word_t expected_change [$];

  function automatic void predict_change(input logic [gcm_pkg::AmountWidth-1:0] amount,
                                         input logic notes);
    int unsigned  rest;
    int unsigned  pieces;
    change_word_t word;
    rest = amount;
    for (int p = (notes ? 0 : FirstCoin); p < 15 && rest != 0; p++) begin
      pieces = rest / EuroDenoms[p];
      if (pieces != 0) begin
        rest        = rest - pieces * EuroDenoms[p];
        word.denom  = EuroDenoms[p][gcm_pkg::DenomWidth-1:0];
        word.pieces = pieces[gcm_pkg::CountWidth-1:0];
        word.last   = (rest == 0);
        expected_change = {expected_change, word};
      end
    end
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    amounts_o    = 0;
    words_o      = 0;
  end

  always @(posedge clk_i) begin : score
    change_word_t got;
    change_word_t want;
    if (rst_ni) begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.denom  = out_mon_i.denomination_cents;
        got.pieces = out_mon_i.piece_count;
        got.last   = out_mon_i.is_last;
        words_o++;
        if (expected_change.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $display("%0t: unexpected change word denom=%0d pieces=%0d last=%0b",
                     $realtime, got.denom, got.pieces, got.last);
          fail_count_o++;
        end else begin
          want = expected_change.pop_front();
          if (got.denom !== want.denom || got.pieces !== want.pieces ||
              got.last !== want.last) begin
            if (fail_count_o < ReportLimit)
              $display("%0t: change word mismatch: expected denom=%0d pieces=%0d last=%0b,",
                       $realtime, want.denom, want.pieces, want.last,
                       " got denom=%0d pieces=%0d last=%0b",
                       got.denom, got.pieces, got.last);
            fail_count_o++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        amounts_o++;
        predict_change(in_mon_i.amount_cents, in_mon_i.use_notes);
      end
      pending_o = expected_change.size();
    end
  end

endmodule

/* tb/greedy_change_maker_core_tb.sv */
// Top of the greedy change maker testbench: clock, reset, amount stimulus,
// result back-pressure, watchdog and verdict. Depends on gcm_pkg, the gcm
// interfaces, greedy_change_maker_core and gcm_change_checker.
`timescale 1ns / 1ps

module greedy_change_maker_core_tb;

  localparam logic CoinSet         = 1'b0;
  localparam logic NoteSet         = 1'b1;
  localparam int   StallAfterWords = 20;
  localparam int   LongStall       = 300;
  localparam int   IdleLimit       = 2000;
  localparam int   SettleCycles    = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   fail_count;
  int   pending_words;
  int   amounts_taken;
  int   words_checked;

  gcm_in_if  change_in ();
  gcm_out_if change_out ();

  greedy_change_maker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (change_in),
    .out_o  (change_out)
  );

  gcm_change_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (change_in),
    .out_mon_i    (change_out),
    .fail_count_o (fail_count),
    .pending_o    (pending_words),
    .amounts_o    (amounts_taken),
    .words_o      (words_checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_amount(input logic [gcm_pkg::AmountWidth-1:0] amount,
                             input logic notes);
    while ($urandom_range(99) < tx_idle_pct) begin
      change_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    change_in.valid        <= 1'b1;
    change_in.amount_cents <= amount;
    change_in.use_notes    <= notes;
    do @(posedge clk_i); while (!change_in.ready);
  endtask

  task automatic send_random(input int count);
    logic [gcm_pkg::AmountWidth-1:0] amount;
    int                              pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(19);
      if (pick == 0)
        amount = '0;
      else if (pick < 9)
        amount = gcm_pkg::AmountWidth'($urandom_range(1000, 1));
      else if (pick < 15)
        amount = gcm_pkg::AmountWidth'($urandom_range(200000, 1));
      else
        amount = gcm_pkg::AmountWidth'($urandom());
      send_amount(amount, 1'($urandom_range(1)));
    end
  endtask

  task automatic drain_results();
    change_in.valid <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    @(posedge clk_i);
  endtask

  // drive ready with random idling, and hold it low for one long stretch once enough words have passed
  initial begin : result_sink
    int words_taken;
    int stall_left;
    bit stall_done;
    words_taken = 0;
    stall_left  = 0;
    stall_done  = 1'b0;
    change_out.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (change_out.valid && change_out.ready)
        words_taken++;
      if (stall_left != 0) begin
        stall_left--;
      end else if (!stall_done && words_taken >= StallAfterWords) begin
        stall_left = LongStall;
        stall_done = 1'b1;
      end
      change_out.ready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((change_in.valid && change_in.ready) || (change_out.valid && change_out.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    tx_idle_pct = 7;
    rx_idle_pct <= 82;
    change_in.valid        <= 1'b0;
    change_in.amount_cents <= '0;
    change_in.use_notes    <= CoinSet;
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_amount(24'd0, CoinSet);
    send_amount(24'd0, NoteSet);
    send_amount(24'd1, CoinSet);
    send_amount(24'd1, NoteSet);
    send_amount(24'd388, CoinSet);
    send_amount(24'd88888, NoteSet);
    send_amount(24'hFFFFFF, CoinSet);
    send_amount(24'hFFFFFF, NoteSet);
    send_amount(24'd50000, NoteSet);
    send_amount(24'd49999, NoteSet);
    send_amount(24'd200, CoinSet);
    send_amount(24'd199, CoinSet);
    send_amount(24'd50000, CoinSet);
    send_amount(24'h800000, NoteSet);
    send_amount(24'h555555, CoinSet);
    send_amount(24'hAAAAAA, NoteSet);
    send_amount(24'd2, CoinSet);
    send_amount(24'd5, NoteSet);
    send_amount(24'd99999, NoteSet);
    send_amount(24'd3, CoinSet);
    send_amount(24'd10, NoteSet);
    send_amount(24'd1000, CoinSet);
    send_random(95);
    drain_results();

    tx_idle_pct = 82;
    rx_idle_pct <= 7;
    send_random(105);
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    send_random(88);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d amounts over coin and note sets, %0d change words checked,",
             amounts_taken, words_checked);
    $display("with idling on both sides, a long result stall and a drained pause.");
    if (fail_count == 0 && pending_words == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
